// ===== design/clwr_pkg.sv =====
// ----------------------------------------------------------------------------
// clwr_pkg
// Shared types and constants for the 4-bit character LCD writer.
// ----------------------------------------------------------------------------
package clwr_pkg;

    localparam int KIND_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 5;
    localparam int NUM_W       = 32;
    localparam int NIB_W       = 4;
    localparam int ADDR_W      = 7;
    localparam int DIGITS      = 10;
    localparam int BCD_W       = DIGITS * NIB_W;
    localparam int BITCNT_W    = $clog2(NUM_W + 1);
    localparam int DIGCNT_W    = $clog2(DIGITS + 1);
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 8;

    localparam logic [BYTE_W-1:0] CURSOR_CMD_BIT = 8'h80;
    localparam logic [ROW_W-1:0]  ROW_COUNT      = 3'd4;
    localparam logic [COL_W-1:0]  COLUMN_COUNT   = 5'd20;
    localparam logic [NIB_W-1:0]  DIGIT_HIGH     = 4'h3;

    typedef enum logic [KIND_W-1:0] {
        KIND_CMD    = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_CURSOR = 2'd2,
        KIND_NUMBER = 2'd3
    } clwr_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CONV,
        ST_SKIP,
        ST_HIGH,
        ST_LOW
    } clwr_state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic digit_shift;
        logic push_high;
        logic push_low;
    } clwr_cmd_t;

    typedef struct packed {
        clwr_kind_t kind;
        logic       cursor_ok;
        logic       conv_done;
        logic       top_zero;
        logic       more_than_two;
        logic       last_digit;
        logic       out_free;
    } clwr_status_t;

    function automatic logic [ADDR_W-1:0] row_base(input logic [1:0] row);
        logic [ADDR_W-1:0] base;
        unique case (row)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h14;
            default: base = 7'h54;
        endcase
        return base;
    endfunction

endpackage

// ===== design/clwr_ctrl.sv =====
// ----------------------------------------------------------------------------
// clwr_ctrl
// Request sequencer: dispatches on the request kind, runs the decimal
// conversion, skips leading zeros and issues high and low nibble transfers.
// ----------------------------------------------------------------------------
module clwr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  clwr_pkg::clwr_status_t status,
    output clwr_pkg::clwr_cmd_t    cmd
);
    import clwr_pkg::*;

    clwr_state_t state_reg;
    clwr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (status.kind)
                    KIND_CMD, KIND_DATA: state_next = ST_HIGH;
                    KIND_CURSOR:         state_next = status.cursor_ok ? ST_HIGH : ST_IDLE;
                    default:             state_next = ST_CONV;
                endcase
            end
            ST_CONV: begin
                if (status.conv_done) begin
                    state_next = ST_SKIP;
                end else begin
                    cmd.conv_step = 1'b1;
                end
            end
            ST_SKIP: begin
                if (status.top_zero && status.more_than_two) begin
                    cmd.digit_shift = 1'b1;
                end else begin
                    state_next = ST_HIGH;
                end
            end
            ST_HIGH: begin
                if (status.out_free) begin
                    cmd.push_high = 1'b1;
                    state_next    = ST_LOW;
                end
            end
            ST_LOW: begin
                if (status.out_free) begin
                    cmd.push_low = 1'b1;
                    if (status.kind == KIND_NUMBER && !status.last_digit) begin
                        cmd.digit_shift = 1'b1;
                        state_next      = ST_HIGH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== design/clwr_dp.sv =====
// ----------------------------------------------------------------------------
// clwr_dp
// Datapath: request capture, cursor address, bit-serial binary to BCD
// conversion, digit shifter and the output transfer register.
// ----------------------------------------------------------------------------
module clwr_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [clwr_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [clwr_pkg::KIND_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [clwr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  clwr_pkg::clwr_cmd_t                 cmd,
    output clwr_pkg::clwr_status_t              status
);
    import clwr_pkg::*;

    logic [BYTE_W-1:0] in_byte;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic [NUM_W-1:0]  in_num;
    logic [ADDR_W-1:0] cursor_addr;

    clwr_kind_t          kind_reg;
    logic                cursor_ok_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [NUM_W-1:0]    bin_reg;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BITCNT_W-1:0] bit_cnt_reg;
    logic [DIGCNT_W-1:0] dig_cnt_reg;
    logic                m_valid_reg;
    logic                m_rs_reg;
    logic [NIB_W-1:0]    m_nib_reg;
    logic                m_last_reg;

    logic [BYTE_W-1:0]   send_byte;
    logic                out_free;
    logic [BCD_W-1:0]    bcd_adj;

    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        r = v;
        for (int i = 0; i < DIGITS; i++) begin
            if (v[i*NIB_W +: NIB_W] >= 4'd5) begin
                r[i*NIB_W +: NIB_W] = v[i*NIB_W +: NIB_W] + 4'd3;
            end
        end
        return r;
    endfunction

    assign in_byte     = s_tdata[7:0];
    assign in_row      = s_tdata[10:8];
    assign in_col      = s_tdata[15:11];
    assign in_num      = s_tdata[47:16];
    assign cursor_addr = row_base(in_row[1:0]) + {{(ADDR_W-COL_W){1'b0}}, in_col};

    assign bcd_adj   = bcd_adjust(bcd_reg);
    assign out_free  = !m_valid_reg || m_tready;
    assign send_byte = (kind_reg == KIND_NUMBER) ? {DIGIT_HIGH, bcd_reg[BCD_W-1 -: NIB_W]}
                                                 : byte_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg      <= clwr_kind_t'(s_tuser);
            cursor_ok_reg <= (in_row < ROW_COUNT) && (in_col < COLUMN_COUNT);
            byte_reg      <= (clwr_kind_t'(s_tuser) == KIND_CURSOR)
                             ? (CURSOR_CMD_BIT | {1'b0, cursor_addr}) : in_byte;
            bin_reg       <= in_num;
            bcd_reg       <= '0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= DIGCNT_W'(DIGITS);
        end else begin
            if (cmd.conv_step) begin
                bcd_reg     <= {bcd_adj[BCD_W-2:0], bin_reg[NUM_W-1]};
                bin_reg     <= {bin_reg[NUM_W-2:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            if (cmd.digit_shift) begin
                bcd_reg     <= {bcd_reg[BCD_W-NIB_W-1:0], {NIB_W{1'b0}}};
                dig_cnt_reg <= dig_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push_high || cmd.push_low) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_high) begin
            m_rs_reg   <= kind_reg[0];
            m_nib_reg  <= send_byte[BYTE_W-1 -: NIB_W];
            m_last_reg <= 1'b0;
        end else if (cmd.push_low) begin
            m_rs_reg   <= kind_reg[0];
            m_nib_reg  <= send_byte[NIB_W-1:0];
            m_last_reg <= (kind_reg != KIND_NUMBER) || (dig_cnt_reg == DIGCNT_W'(1));
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-NIB_W){1'b0}}, m_nib_reg};
    assign m_tuser  = m_rs_reg;
    assign m_tlast  = m_last_reg;

    assign status.kind          = kind_reg;
    assign status.cursor_ok     = cursor_ok_reg;
    assign status.conv_done     = (bit_cnt_reg == BITCNT_W'(NUM_W));
    assign status.top_zero      = (bcd_reg[BCD_W-1 -: NIB_W] == '0);
    assign status.more_than_two = (dig_cnt_reg > DIGCNT_W'(2));
    assign status.last_digit    = (dig_cnt_reg == DIGCNT_W'(1));
    assign status.out_free      = out_free;

endmodule

// ===== design/char_lcd_four_bit_writer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_four_bit_writer
// Turns command, data, cursor and decimal integer requests into 4-bit
// nibble transfers for a character LCD, high nibble first.
//
//   channel  direction  tdata                                tuser   tlast
//   s_       in         byte_value, row, column, number      kind    -
//   m_       out        nibble                               rs      last
//
// Command, data and in-range cursor requests each give a high and a low
// nibble transfer; an out-of-range cursor request is dropped without one.
// An integer request runs the bit-serial BCD converter, skips leading zeros
// while keeping at least two digits, then sends a high and a low nibble for
// each digit. A new request is taken only once the previous one has issued
// its last transfer or been dropped; a stalled m_tready holds the sequencer. Reset is synchronous.
// ----------------------------------------------------------------------------
module char_lcd_four_bit_writer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [clwr_pkg::S_TDATA_W-1:0]  s_tdata,  // byte_value, row, column, number
    input  logic [clwr_pkg::KIND_W-1:0]     s_tuser,  // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [clwr_pkg::M_TDATA_W-1:0]  m_tdata,  // nibble, zero pad
    output logic                            m_tuser,  // register_select
    output logic                            m_tlast
);
    import clwr_pkg::*;

    clwr_cmd_t    cmd;
    clwr_status_t status;

    clwr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    clwr_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
